### design/point_scale_rotate_translate_unit_assert.svh
// Assertion macros used by the checker file of the point transform unit.
// Needs a clock and an active-low reset name at each use.
`ifndef POINT_SCALE_ROTATE_TRANSLATE_UNIT_ASSERT_SVH
`define POINT_SCALE_ROTATE_TRANSLATE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PSRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("psrt assertion failed");

// antecedent implies a delayed consequent, the delay given by argument n
`define PSRT_ASSERT_LATER(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("psrt assertion failed");

`endif

### design/psrt_pkg.sv
// Package for the point scale/rotate/translate unit: widths, constants, register codes.
// No dependencies.
package psrt_pkg;

	localparam int COORD_W    = 32;
	localparam int ANG_W      = 16;
	localparam int TRIG_W     = 16;
	localparam int MID_W      = 40;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int SCALE_FRAC = 16;
	localparam int TRIG_FRAC  = 14;

	localparam int ONE_Q14 = 16384;
	localparam int POLY_A  = 25736;
	localparam int POLY_B  = 10512;
	localparam int POLY_C  = 1160;

	// transaction latency from accepted start to done strobe
	localparam int LATENCY = 12;

	localparam logic [COORD_W-1:0]    SCALE_RESET  = 32'h0001_0000;
	localparam logic [CFG_DATA_W-1:0] ANGLES_RESET = '0;
	localparam logic [COORD_W-1:0]    SHIFT_RESET  = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_X = 3'd0,
		REG_SCALE_Y = 3'd1,
		REG_SCALE_Z = 3'd2,
		REG_ANGLES  = 3'd3,
		REG_SHIFT_X = 3'd4,
		REG_SHIFT_Y = 3'd5,
		REG_SHIFT_Z = 3'd6
	} cfg_reg_t;

endpackage

### design/point_scale_rotate_translate_unit.sv
// Point scale, Euler rotation (z, x, y) and translation unit, Q16.16 in and out.
// Depends on psrt_pkg, psrt_trig, psrt_scale, psrt_rot.
//
// One point per start pulse, accepted every cycle (busy is never raised). Each
// transaction returns its point with done high for one cycle; the receiver
// cannot hold results off, and results leave in order. Latency is set by the
// pipeline: four scale stages, two for each of the three rotation steps, and two
// for translation and saturation. Sine and cosine values are recomputed by a
// four-stage pipeline from the angles register, in step with config writes, so a
// point may start right after any write.
module point_scale_rotate_translate_unit import psrt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] in_x,
	input  logic signed [COORD_W-1:0] in_y,
	input  logic signed [COORD_W-1:0] in_z,
	output logic                      done,
	output logic signed [COORD_W-1:0] out_x,
	output logic signed [COORD_W-1:0] out_y,
	output logic signed [COORD_W-1:0] out_z,
	output logic                      clipped,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_idx,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	localparam int W1 = MID_W + 3;
	localparam int W2 = W1 + 3;
	localparam int W3 = W2 + 3;
	localparam int SUM_W = W3 + 1;

	logic signed [COORD_W-1:0] scale_q [3];
	logic signed [COORD_W-1:0] shift_q [3];
	logic [CFG_DATA_W-1:0]     angles_q, angles_d;

	logic signed [TRIG_W-1:0]  sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
	logic signed [COORD_W-1:0] in_c [3];

	logic                      sc_valid, sc_clip;
	logic signed [MID_W-1:0]   sc_c [3];

	logic                      rz_valid, rx_valid, ry_valid;
	logic signed [W1-1:0]      x1, y1;
	logic [MID_W:0]            rz_pass;
	logic signed [W2-1:0]      y2, z2;
	logic [W1:0]               rx_pass;
	logic signed [W3-1:0]      z3, x3;
	logic [W2:0]               ry_pass;

	logic                      valid_s11, valid_s12;
	logic signed [SUM_W-1:0]   sum_s11 [3];
	logic                      clip_s11, clip_s12;
	logic signed [COORD_W-1:0] res_s12 [3];
	logic signed [SUM_W-1:0]   sum_c [3];
	logic [2:0]                sat;

	assign busy = 1'b0;

	// config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				scale_q[i] <= SCALE_RESET;
				shift_q[i] <= SHIFT_RESET;
			end
			angles_q <= ANGLES_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_SCALE_X: scale_q[0] <= cfg_data[COORD_W-1:0];
				REG_SCALE_Y: scale_q[1] <= cfg_data[COORD_W-1:0];
				REG_SCALE_Z: scale_q[2] <= cfg_data[COORD_W-1:0];
				REG_ANGLES:  angles_q   <= cfg_data;
				REG_SHIFT_X: shift_q[0] <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Y: shift_q[1] <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Z: shift_q[2] <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// trig pipeline sees a new angle in the cycle it is written
	assign angles_d = (cfg_we && cfg_reg_t'(cfg_idx) == REG_ANGLES) ? cfg_data : angles_q;

	psrt_trig u_trig_x (.clk(clk), .angle(angles_d[ANG_W-1:0]),         .sin_v(sin_x), .cos_v(cos_x));
	psrt_trig u_trig_y (.clk(clk), .angle(angles_d[2*ANG_W-1:ANG_W]),   .sin_v(sin_y), .cos_v(cos_y));
	psrt_trig u_trig_z (.clk(clk), .angle(angles_d[3*ANG_W-1:2*ANG_W]), .sin_v(sin_z), .cos_v(cos_z));

	assign in_c[0] = in_x;
	assign in_c[1] = in_y;
	assign in_c[2] = in_z;

	psrt_scale u_scale (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.in_c(in_c), .scale(scale_q),
		.out_valid(sc_valid), .out_c(sc_c), .out_clip(sc_clip)
	);

	// z turn on (x, y)
	psrt_rot #(.IN_W(MID_W), .PASS_W(MID_W + 1)) u_rot_z (
		.clk(clk), .arst_n(arst_n), .in_valid(sc_valid),
		.a(sc_c[0]), .b(sc_c[1]), .c(cos_z), .s(sin_z),
		.pass_in({sc_c[2], sc_clip}),
		.out_valid(rz_valid), .o1(x1), .o2(y1), .pass_out(rz_pass)
	);

	// x turn on (y, z)
	psrt_rot #(.IN_W(W1), .PASS_W(W1 + 1)) u_rot_x (
		.clk(clk), .arst_n(arst_n), .in_valid(rz_valid),
		.a(y1), .b(W1'($signed(rz_pass[MID_W:1]))), .c(cos_x), .s(sin_x),
		.pass_in({x1, rz_pass[0]}),
		.out_valid(rx_valid), .o1(y2), .o2(z2), .pass_out(rx_pass)
	);

	// y turn on (z, x): z' = z*c - x*s, x' = z*s + x*c
	psrt_rot #(.IN_W(W2), .PASS_W(W2 + 1)) u_rot_y (
		.clk(clk), .arst_n(arst_n), .in_valid(rx_valid),
		.a(z2), .b(W2'($signed(rx_pass[W1:1]))), .c(cos_y), .s(sin_y),
		.pass_in({y2, rx_pass[0]}),
		.out_valid(ry_valid), .o1(z3), .o2(x3), .pass_out(ry_pass)
	);

	// translation sums and saturation checks
	always_comb begin
		sum_c[0] = SUM_W'(x3) + SUM_W'(shift_q[0]);
		sum_c[1] = SUM_W'($signed(ry_pass[W2:1])) + SUM_W'(shift_q[1]);
		sum_c[2] = SUM_W'(z3) + SUM_W'(shift_q[2]);
		for (int i = 0; i < 3; i++)
			sat[i] = (sum_s11[i][SUM_W-1:COORD_W-1] != '0) && (sum_s11[i][SUM_W-1:COORD_W-1] != '1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else begin
			valid_s11 <= ry_valid;
			valid_s12 <= valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		sum_s11  <= sum_c;
		clip_s11 <= ry_pass[0];
		for (int i = 0; i < 3; i++) begin
			if (sat[i])
				res_s12[i] <= sum_s11[i][SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
				                                  : {1'b0, {(COORD_W-1){1'b1}}};
			else
				res_s12[i] <= sum_s11[i][COORD_W-1:0];
		end
		clip_s12 <= clip_s11 || (|sat);
	end

	assign done    = valid_s12;
	assign out_x   = res_s12[0];
	assign out_y   = res_s12[1];
	assign out_z   = res_s12[2];
	assign clipped = clip_s12;

endmodule

### design/psrt_trig.sv
// Pipelined Q2.14 sine and cosine of one 16-bit binary angle, four register stages.
// Depends on psrt_pkg.
module psrt_trig import psrt_pkg::*; (
	input  logic                     clk,
	input  logic [ANG_W-1:0]         angle,
	output logic signed [TRIG_W-1:0] sin_v,
	output logic signed [TRIG_W-1:0] cos_v
);

	// lane 0 is sine, lane 1 is cosine (angle plus a quarter turn)
	logic [ANG_W-1:0]  ang [2];
	logic [14:0]       t_c [2];
	logic [29:0]       tt_c [2];
	logic [25:0]       cp_c [2];
	logic [28:0]       m_c [2];
	logic [29:0]       r_c [2];

	logic [14:0]       t_s1 [2], t_s2 [2], t_s3 [2];
	logic [14:0]       t2_s1 [2], t2_s2 [2];
	logic [13:0]       pb_s2 [2];
	logic [14:0]       pa_s3 [2];
	logic              neg_s1 [2], neg_s2 [2], neg_s3 [2];
	logic signed [TRIG_W-1:0] res_s4 [2];

	assign ang[0] = angle;
	assign ang[1] = angle + ANG_W'(ONE_Q14);

	// products of each step
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			t_c[l]  = ang[l][14] ? (15'(ONE_Q14) - {1'b0, ang[l][13:0]}) : {1'b0, ang[l][13:0]};
			tt_c[l] = t_c[l] * t_c[l];
			cp_c[l] = 26'(11'(POLY_C) * t2_s1[l]);
			m_c[l]  = pb_s2[l] * t2_s2[l];
			r_c[l]  = pa_s3[l] * t_s3[l];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			t_s1[l]   <= t_c[l];
			t2_s1[l]  <= tt_c[l][28:14];
			neg_s1[l] <= ang[l][15];

			t_s2[l]   <= t_s1[l];
			t2_s2[l]  <= t2_s1[l];
			neg_s2[l] <= neg_s1[l];
			pb_s2[l]  <= 14'(POLY_B) - cp_c[l][25:14];

			t_s3[l]   <= t_s2[l];
			neg_s3[l] <= neg_s2[l];
			pa_s3[l]  <= 15'(POLY_A) - m_c[l][28:14];

			res_s4[l] <= neg_s3[l] ? -$signed({1'b0, r_c[l][28:14]})
			                       :  $signed({1'b0, r_c[l][28:14]});
		end
	end

	assign sin_v = res_s4[0];
	assign cos_v = res_s4[1];

endmodule

### design/psrt_scale.sv
// Per-axis scale: capture, multiply, round, clamp to Q24.16 (four stages).
// Depends on psrt_pkg.
module psrt_scale import psrt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [COORD_W-1:0] in_c [3],
	input  logic signed [COORD_W-1:0] scale [3],
	output logic                      out_valid,
	output logic signed [MID_W-1:0]   out_c [3],
	output logic                      out_clip
);

	localparam int PROD_W = 2 * COORD_W;
	localparam int RND_W  = PROD_W - SCALE_FRAC;
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (SCALE_FRAC - 1);

	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [COORD_W-1:0] c_s1 [3];
	logic signed [PROD_W-1:0]  prod_s2 [3];
	logic signed [RND_W-1:0]   rnd_s3 [3];
	logic signed [MID_W-1:0]   mid_s4 [3];
	logic                      clip_s4;
	logic signed [PROD_W-1:0]  rsum [3];
	logic [2:0]                ovf;

	// round half up, then check the 40-bit range
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rsum[i] = prod_s2[i] + HALF;
			ovf[i]  = (rnd_s3[i][RND_W-1:MID_W-1] != '0) && (rnd_s3[i][RND_W-1:MID_W-1] != '1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			c_s1[i]    <= in_c[i];
			prod_s2[i] <= c_s1[i] * scale[i];
			rnd_s3[i]  <= rsum[i][PROD_W-1:SCALE_FRAC];
			if (ovf[i])
				mid_s4[i] <= rnd_s3[i][RND_W-1] ? {1'b1, {(MID_W-1){1'b0}}}
				                                : {1'b0, {(MID_W-1){1'b1}}};
			else
				mid_s4[i] <= rnd_s3[i][MID_W-1:0];
		end
		clip_s4 <= |ovf;
	end

	assign out_valid = valid_s4;
	assign out_c     = mid_s4;
	assign out_clip  = clip_s4;

endmodule

### design/psrt_rot.sv
// One plane rotation step: o1 = a*c - b*s, o2 = a*s + b*c, rounded by 2^14.
// Two stages (products, sums); carries a side vector alongside. Depends on psrt_pkg.
module psrt_rot import psrt_pkg::*; #(
	parameter int IN_W   = 40,
	parameter int PASS_W = 41
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [IN_W-1:0]   a,
	input  logic signed [IN_W-1:0]   b,
	input  logic signed [TRIG_W-1:0] c,
	input  logic signed [TRIG_W-1:0] s,
	input  logic [PASS_W-1:0]        pass_in,
	output logic                     out_valid,
	output logic signed [IN_W+2:0]   o1,
	output logic signed [IN_W+2:0]   o2,
	output logic [PASS_W-1:0]        pass_out
);

	localparam int PW = IN_W + TRIG_W;
	localparam logic signed [PW:0] HALF = (PW+1)'(1) << (TRIG_FRAC - 1);

	logic                   valid_s1, valid_s2;
	logic signed [PW-1:0]   ac_s1, bs_s1, as_s1, bc_s1;
	logic [PASS_W-1:0]      pass_s1, pass_s2;
	logic signed [PW:0]     d1, d2;
	logic signed [IN_W+2:0] o1_s2, o2_s2;

	// signed sums with round half up
	always_comb begin
		d1 = PW'(ac_s1) - PW'(bs_s1) + HALF;
		d2 = PW'(as_s1) + PW'(bc_s1) + HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ac_s1   <= a * c;
		bs_s1   <= b * s;
		as_s1   <= a * s;
		bc_s1   <= b * c;
		pass_s1 <= pass_in;
		o1_s2   <= d1[PW:TRIG_FRAC];
		o2_s2   <= d2[PW:TRIG_FRAC];
		pass_s2 <= pass_s1;
	end

	assign out_valid = valid_s2;
	assign o1        = o1_s2;
	assign o2        = o2_s2;
	assign pass_out  = pass_s2;

endmodule

### design/psrt_checker.sv
// Port-level checks for the point transform unit, bound to the top level.
// Depends on psrt_pkg and point_scale_rotate_translate_unit_assert.svh.
`include "point_scale_rotate_translate_unit_assert.svh"

module psrt_checker import psrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// every point is taken
	`PSRT_ASSERT_NOW(a_never_busy, clk, arst_n, start, !busy)
	// each accepted transaction is answered by a done strobe
	`PSRT_ASSERT_LATER(a_done_follows, clk, arst_n, start && !busy, LATENCY, done)
	// no result without a transaction behind it
	`PSRT_ASSERT_NOW(a_done_has_source, clk, arst_n, done, $past(start && !busy, LATENCY))

endmodule

bind point_scale_rotate_translate_unit psrt_checker u_psrt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);
